// File: sv/duart_pkg.sv
// Package: opcodes, register offsets, status and interrupt bit constants.
`default_nettype none
package duart_pkg;
  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_TICK    = 3'd2,
    OP_RX_A    = 3'd3,
    OP_RX_B    = 3'd4,
    OP_POP     = 3'd5,
    OP_CHG     = 3'd6,
    OP_NONE    = 3'd7
  } op_e;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_CSR  = 3'd1;
  localparam logic [2:0] REG_CMD  = 3'd2;
  localparam logic [2:0] REG_DATA = 3'd3;

  localparam logic [3:0] REG_ACR   = 4'h4;
  localparam logic [3:0] REG_IMR   = 4'h5;
  localparam logic [3:0] REG_CTUR  = 4'h6;
  localparam logic [3:0] REG_CTLR  = 4'h7;
  localparam logic [3:0] REG_IVR   = 4'hC;
  localparam logic [3:0] REG_OPCR  = 4'hD;
  localparam logic [3:0] REG_OPSET = 4'hE;
  localparam logic [3:0] REG_OPCLR = 4'hF;

  localparam logic [7:0] ST_RXRDY  = 8'h01;
  localparam logic [7:0] ST_RXFULL = 8'h02;
  localparam logic [7:0] ST_TXRDY  = 8'h04;
  localparam logic [7:0] ST_TXEMT  = 8'h08;
  localparam logic [7:0] IRQ_CNT   = 8'h08;
  localparam logic [7:0] IVR_RESET = 8'h0F;
  localparam logic [15:0] TXD_RESET = 16'd100;

  // event entry: cmd, m2, m1, clk, byte, chan (chan in bit 0)
  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] m2;
    logic [7:0] m1;
    logic [7:0] clk;
    logic [7:0] byte_v;
    logic       chan;
  } evt_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] read_data;
    logic       done_flag;
    logic       pop;
    logic [7:0] port_level;
  } res_t;
endpackage
`default_nettype wire

// File: sv/duart_evq.sv
// Transmit event queue: synchronous memory with drop-oldest on overflow.
`default_nettype none
module duart_evq #(
  parameter int EVENT_DEPTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [1:0]      push_i,
  input  wire duart_pkg::evt_t evt_a_i,
  input  wire duart_pkg::evt_t evt_b_i,
  input  wire logic            pop_i,
  output logic                 pop_ok_o,
  output duart_pkg::evt_t      rd_data_o
);
  import duart_pkg::*;
  localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int PW = AW + 1;
  localparam int EW = $bits(evt_t);

  logic [EW-1:0] mem [EVENT_DEPTH];
  logic [PW-1:0] rd_q, wr_q, rd_d, wr_d, rd_mid, wr_mid;
  evt_t          rdata_q;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    logic [PW:0] s;
    s = {1'b0, p} + 1'b1;
    if (s >= (PW+1)'(2 * EVENT_DEPTH)) s = '0;
    return s[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] idx(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p >= PW'(EVENT_DEPTH)) ? p - PW'(EVENT_DEPTH) : p;
    return r[AW-1:0];
  endfunction

  function automatic logic full(input logic [PW-1:0] w, input logic [PW-1:0] r);
    return (w != r) && (idx(w) == idx(r));
  endfunction

  assign pop_ok_o = (rd_q != wr_q);

  // two pushes in one item: A then B, each may drop the oldest entry
  always_comb begin
    rd_mid = rd_q;
    wr_mid = wr_q;
    if (push_i[0]) begin
      if (full(wr_mid, rd_mid)) rd_mid = inc(rd_mid);
      wr_mid = inc(wr_mid);
    end
    rd_d = rd_mid;
    wr_d = wr_mid;
    if (push_i[1]) begin
      if (full(wr_d, rd_d)) rd_d = inc(rd_d);
      wr_d = inc(wr_d);
    end
    if (pop_i && pop_ok_o) rd_d = inc(rd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  // pushes and pops never share an item; two write ports (A, B) and one read port
  always_ff @(posedge clk_i) begin
    if (push_i[0]) mem[idx(wr_q)] <= evt_a_i;
    if (push_i[1]) mem[idx(push_i[0] ? inc(wr_q) : wr_q)] <= evt_b_i;
    rdata_q <= mem[idx(rd_q)];
  end

  assign rd_data_o = rdata_q;
endmodule
`default_nettype wire

// File: sv/dual_uart_register_model.sv
// Top level: two-channel UART register block with transmit event queue.
// Result word is registered: valid in the cycle after the input word is accepted.
// Throughput: one word per cycle; input stalls only when the output register is
// full and not taken. Pops read the event memory whose data is registered.
// Reset clears all control and register state at once; the event memory is
// not cleared (only queued entries are ever read).
`default_nettype none
module dual_uart_register_model #(
  parameter int EVENT_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[2:0], reg_offset[6:3], bus_data[14:7], tick_cycles[46:15]
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data[7:0], done_flag[8], event_channel[9], event_byte[17:10],
  // event_clock_select[25:18], event_mode_one[33:26], event_mode_two[41:34],
  // event_command[49:42], port_level[57:50]
  output logic [63:0]      m_axis_tdata
);
  import duart_pkg::*;

  logic [15:0] txd_q;
  logic [7:0]  m1_q [2], m2_q [2], csr_q [2], cmd_q [2], st_q [2], txb_q [2], rxb_q [2];
  logic [15:0] wait_q [2];
  logic        mp_q [2], rxon_q [2], txon_q [2];
  logic [7:0]  acr_q, isr_q, imr_q, ivr_q, opcr_q, opr_q, pins_q, chg_q;
  logic [15:0] rel_q, cnt_q;
  logic        run_q;

  logic [7:0]  m1_d [2], m2_d [2], csr_d [2], cmd_d [2], st_d [2], txb_d [2], rxb_d [2];
  logic [15:0] wait_d [2];
  logic        mp_d [2], rxon_d [2], txon_d [2];
  logic [7:0]  acr_d, isr_d, imr_d, ivr_d, opcr_d, opr_d, pins_d, chg_d;
  logic [15:0] rel_d, cnt_d;
  logic        run_d;

  logic        acc;
  op_e         op;
  logic [3:0]  off;
  logic [7:0]  dat;
  logic [31:0] cyc;
  logic        c;
  logic [7:0]  rdat;
  logic        done;
  logic [1:0]  push;
  evt_t        ev [2];
  evt_t        q_rd;
  logic        pop_ok;
  res_t        res_q;
  logic        pend;
  logic        is_pop;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !res_q.valid || m_axis_tready;
  assign op  = op_e'(s_axis_tdata[2:0]);
  assign off = s_axis_tdata[6:3];
  assign dat = s_axis_tdata[14:7];
  assign cyc = s_axis_tdata[46:15];
  assign c   = off[3];
  assign is_pop = acc && (op == OP_POP);

  always_comb begin
    logic [7:0] irx, itx, v;
    for (int k = 0; k < 2; k++) begin
      m1_d[k] = m1_q[k]; m2_d[k] = m2_q[k]; csr_d[k] = csr_q[k]; cmd_d[k] = cmd_q[k];
      st_d[k] = st_q[k]; txb_d[k] = txb_q[k]; rxb_d[k] = rxb_q[k]; wait_d[k] = wait_q[k];
      mp_d[k] = mp_q[k]; rxon_d[k] = rxon_q[k]; txon_d[k] = txon_q[k];
    end
    acr_d = acr_q; isr_d = isr_q; imr_d = imr_q; ivr_d = ivr_q; opcr_d = opcr_q;
    opr_d = opr_q; pins_d = pins_q; chg_d = chg_q; rel_d = rel_q; cnt_d = cnt_q;
    run_d = run_q;
    rdat = '0;
    done = 1'b0;
    push = '0;
    irx = c ? 8'h20 : 8'h02;
    itx = c ? 8'h10 : 8'h01;
    v = 8'h00;
    for (int k = 0; k < 2; k++) begin
      ev[k].chan = 1'(k); ev[k].byte_v = txb_q[k]; ev[k].clk = csr_q[k];
      ev[k].m1 = m1_q[k]; ev[k].m2 = m2_q[k]; ev[k].cmd = cmd_q[k];
    end
    if (acc) begin
      case (op)
        OP_WRITE: begin
          case (off)
            4'h0, 4'h8: if (!mp_q[c]) begin m1_d[c] = dat; mp_d[c] = 1'b1; end
                        else m2_d[c] = dat;
            4'h1, 4'h9: csr_d[c] = dat;
            4'h2, 4'hA: begin
              cmd_d[c] = dat;
              if (dat[0]) rxon_d[c] = 1'b1;
              if (dat[1]) rxon_d[c] = 1'b0;
              if (dat[2]) begin
                txon_d[c] = 1'b1; st_d[c] = st_d[c] | ST_TXRDY | ST_TXEMT; isr_d = isr_d | itx;
              end
              if (dat[3]) begin
                txon_d[c] = 1'b0; st_d[c] = st_d[c] & ~(ST_TXRDY | ST_TXEMT);
                isr_d = isr_d & ~itx;
              end
              case (dat[6:4])
                3'd1: mp_d[c] = 1'b0;
                3'd2: begin st_d[c] = st_d[c] & ~(ST_RXRDY | ST_RXFULL); isr_d = isr_d & ~irx; end
                3'd3: begin st_d[c] = st_d[c] & ~(ST_TXRDY | ST_TXEMT); isr_d = isr_d & ~itx; end
                default: ;
              endcase
            end
            4'h3, 4'hB: begin
              txb_d[c] = dat;
              st_d[c] = st_d[c] & ~(ST_TXRDY | ST_TXEMT);
              isr_d = isr_d & ~itx;
              wait_d[c] = (txd_q != 16'd0) ? txd_q : 16'd1;
              if (m2_q[c][7] && rxon_q[c] && !(c && st_q[c][0])) begin
                rxb_d[c] = dat; st_d[c] = st_d[c] | ST_RXRDY | ST_RXFULL; isr_d = isr_d | irx;
              end
            end
            REG_ACR:  acr_d = dat;
            REG_IMR:  imr_d = dat;
            REG_CTUR: rel_d = {dat, rel_q[7:0]};
            REG_CTLR: rel_d = {rel_q[15:8], dat};
            REG_IVR:  ivr_d = dat;
            REG_OPCR: opcr_d = dat;
            REG_OPSET: begin
              opr_d = opr_q | dat; pins_d = ~opr_d; chg_d = chg_q | (pins_q ^ pins_d);
            end
            default: begin
              opr_d = opr_q & ~dat; pins_d = ~opr_d; chg_d = chg_q | (pins_q ^ pins_d);
            end
          endcase
        end
        OP_READ: begin
          case (off)
            4'h0, 4'h8: begin rdat = mp_q[c] ? m2_q[c] : m1_q[c]; mp_d[c] = 1'b1; end
            4'h1, 4'h9: rdat = st_q[c];
            4'h3, 4'hB: begin
              st_d[c] = st_q[c] & ~(ST_RXRDY | ST_RXFULL); isr_d = isr_q & ~irx; rdat = rxb_q[c];
            end
            4'h4, 4'hD: rdat = 8'hFF;
            4'h5: rdat = isr_q;
            4'h6: rdat = cnt_q[15:8];
            4'h7: rdat = cnt_q[7:0];
            4'hC: rdat = ivr_q;
            4'hE: begin run_d = 1'b1; cnt_d = rel_q; isr_d = isr_q & ~IRQ_CNT; rdat = rel_q[15:8]; end
            4'hF: begin run_d = 1'b0; isr_d = isr_q & ~IRQ_CNT; rdat = cnt_q[7:0]; end
            default: rdat = v;
          endcase
        end
        OP_TICK: begin
          for (int k = 0; k < 2; k++) begin
            if (wait_q[k] != 16'd0) begin
              if (cyc >= {16'd0, wait_q[k]}) begin
                wait_d[k] = '0; st_d[k] = st_q[k] | ST_TXRDY | ST_TXEMT;
                isr_d = isr_d | ((k == 1) ? 8'h10 : 8'h01);
                push[k] = 1'b1; done = 1'b1;
              end else wait_d[k] = wait_q[k] - cyc[15:0];
            end
          end
          if (run_q && rel_q != 16'd0) begin
            if (cyc >= {16'd0, cnt_q}) begin cnt_d = rel_q; isr_d = isr_d | IRQ_CNT; end
            else cnt_d = cnt_q - cyc[15:0];
          end
        end
        OP_RX_A: if (rxon_q[0]) begin
          rxb_d[0] = dat; st_d[0] = st_q[0] | ST_RXRDY | ST_RXFULL; isr_d = isr_q | 8'h02;
        end
        OP_RX_B: if (rxon_q[1] && !st_q[1][0]) begin
          rxb_d[1] = dat; st_d[1] = st_q[1] | ST_RXRDY | ST_RXFULL; isr_d = isr_q | 8'h20;
          done = 1'b1;
        end
        OP_POP: done = pop_ok;
        OP_CHG: begin rdat = chg_q; chg_d = '0; end
        default: ;
      endcase
    end
  end

  duart_evq #(.EVENT_DEPTH(EVENT_DEPTH)) u_evq (
    .clk_i, .rst_ni, .push_i(push), .evt_a_i(ev[0]), .evt_b_i(ev[1]),
    .pop_i(is_pop), .pop_ok_o(pop_ok), .rd_data_o(q_rd)
  );

  // memory read data is registered: it aligns with res_q
  logic pop_fix_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txd_q <= TXD_RESET;
      for (int k = 0; k < 2; k++) begin
        m1_q[k] <= '0; m2_q[k] <= '0; csr_q[k] <= '0; cmd_q[k] <= '0; st_q[k] <= '0;
        txb_q[k] <= '0; rxb_q[k] <= '0; wait_q[k] <= '0; mp_q[k] <= 1'b0;
        rxon_q[k] <= 1'b0; txon_q[k] <= 1'b0;
      end
      acr_q <= '0; isr_q <= '0; imr_q <= '0; ivr_q <= IVR_RESET; opcr_q <= '0;
      opr_q <= '0; pins_q <= 8'hFF; chg_q <= '0; rel_q <= '0; cnt_q <= '0; run_q <= 1'b0;
      res_q <= '0;
      pop_fix_q <= 1'b0;
    end else begin
      if (cfg_we_i) txd_q <= cfg_wdata_i;
      for (int k = 0; k < 2; k++) begin
        m1_q[k] <= m1_d[k]; m2_q[k] <= m2_d[k]; csr_q[k] <= csr_d[k]; cmd_q[k] <= cmd_d[k];
        st_q[k] <= st_d[k]; txb_q[k] <= txb_d[k]; rxb_q[k] <= rxb_d[k];
        wait_q[k] <= wait_d[k]; mp_q[k] <= mp_d[k]; rxon_q[k] <= rxon_d[k];
        txon_q[k] <= txon_d[k];
      end
      acr_q <= acr_d; isr_q <= isr_d; imr_q <= imr_d; ivr_q <= ivr_d; opcr_q <= opcr_d;
      opr_q <= opr_d; pins_q <= pins_d; chg_q <= chg_d; rel_q <= rel_d; cnt_q <= cnt_d;
      run_q <= run_d;
      if (acc) begin
        res_q.valid <= 1'b1; res_q.read_data <= rdat; res_q.done_flag <= done;
        res_q.pop <= is_pop && pop_ok; res_q.port_level <= pins_d;
        pop_fix_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_q.valid <= 1'b0;
        pop_fix_q <= 1'b0;
      end
    end
  end

  // hold the popped event while the output stalls
  evt_t ev_hold_q, ev_out;
  always_ff @(posedge clk_i) begin
    if (pop_fix_q) ev_hold_q <= ev_out;
  end
  logic first_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) first_q <= 1'b0;
    else first_q <= acc;
  end
  assign ev_out = first_q ? q_rd : ev_hold_q;
  assign pend = res_q.pop;

  assign m_axis_tvalid = res_q.valid;
  assign m_axis_tdata = {6'd0, res_q.port_level,
                         pend ? ev_out.cmd : 8'd0, pend ? ev_out.m2 : 8'd0,
                         pend ? ev_out.m1 : 8'd0, pend ? ev_out.clk : 8'd0,
                         pend ? ev_out.byte_v : 8'd0, pend & ev_out.chan,
                         res_q.done_flag, res_q.read_data};

  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.pop |-> res_q.done_flag) else $error("pop without done");
  a_valid_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> m_axis_tvalid) else $error("result lost");
  a_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pins_q == ~opr_q) else $error("pins mismatch");
endmodule
`default_nettype wire

// File: dv/duart_checker.sv
// Checker: predicts each result word of the dual UART block and compares it.
`timescale 1ns / 1ps
module duart_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [63:0] m_axis_tdata,
  output int               pending_o,
  output int               fails_o,
  output int               results_o
);
  import duart_pkg::*;

  typedef struct packed {
    logic [7:0] port_level;
    logic [7:0] command;
    logic [7:0] mode_two;
    logic [7:0] mode_one;
    logic [7:0] clock_select;
    logic [7:0] byte_v;
    logic       channel;
    logic       done;
    logic [7:0] read_data;
  } uart_result_t;

  uart_result_t expected_q[$];

  logic [15:0] tx_delay;
  logic [7:0]  mode_one[2], mode_two[2], clk_sel[2], cmd_last[2], status[2];
  logic [7:0]  tx_hold[2], rx_hold[2];
  logic        mode_ptr[2], rx_on[2], tx_on[2];
  logic [15:0] tx_wait[2];
  logic [7:0]  aux, irq_stat, irq_msk, irq_vec, op_cfg, op_reg, op_pins, op_changed;
  logic [15:0] cnt_reload, cnt_now;
  logic        cnt_run;
  evt_t        evt_mem[16];
  logic [4:0]  evt_rd, evt_wr;

  function automatic logic [7:0] tx_irq(logic c);
    return c ? 8'h10 : 8'h01;
  endfunction

  function automatic logic [7:0] rx_irq(logic c);
    return c ? 8'h20 : 8'h02;
  endfunction

  function automatic void clear_state();
    for (int c = 0; c < 2; c++) begin
      mode_one[c] = 0; mode_two[c] = 0; clk_sel[c] = 0; cmd_last[c] = 0;
      status[c] = 0; tx_hold[c] = 0; rx_hold[c] = 0; mode_ptr[c] = 0;
      rx_on[c] = 0; tx_on[c] = 0; tx_wait[c] = 0;
    end
    tx_delay = TXD_RESET;
    aux = 0; irq_stat = 0; irq_msk = 0; irq_vec = IVR_RESET;
    op_cfg = 0; op_reg = 0; op_pins = 8'hFF; op_changed = 0;
    cnt_reload = 0; cnt_now = 0; cnt_run = 0; evt_rd = 0; evt_wr = 0;
  endfunction

  function automatic logic take_byte(logic c, logic [7:0] v);
    if (!rx_on[c]) return 1'b0;
    if (c && (status[c] & ST_RXRDY)) return 1'b0;
    rx_hold[c] = v;
    status[c] |= ST_RXRDY | ST_RXFULL;
    irq_stat |= rx_irq(c);
    return 1'b1;
  endfunction

  function automatic void tx_stop(logic c);
    status[c] &= ~(ST_TXRDY | ST_TXEMT);
    irq_stat &= ~tx_irq(c);
  endfunction

  function automatic void drive_pins(logic [7:0] r);
    logic [7:0] prev;
    prev = op_pins;
    op_reg = r;
    op_pins = ~r;
    op_changed |= prev ^ op_pins;
  endfunction

  function automatic void queue_event(logic c);
    evt_t e;
    if (5'(evt_wr - evt_rd) >= 5'd16) evt_rd = evt_rd + 5'd1;
    e.chan = c; e.byte_v = tx_hold[c]; e.clk = clk_sel[c];
    e.m1 = mode_one[c]; e.m2 = mode_two[c]; e.cmd = cmd_last[c];
    evt_mem[evt_wr[3:0]] = e;
    evt_wr = evt_wr + 5'd1;
  endfunction

  function automatic void write_reg(logic [3:0] off, logic [7:0] v);
    logic c;
    logic ok;
    c = off[3];
    if (!off[2]) begin
      case (off[2:0])
        REG_MODE: begin
          if (!mode_ptr[c]) begin
            mode_one[c] = v; mode_ptr[c] = 1;
          end else mode_two[c] = v;
        end
        REG_CSR: clk_sel[c] = v;
        REG_CMD: begin
          cmd_last[c] = v;
          if (v[0]) rx_on[c] = 1;
          if (v[1]) rx_on[c] = 0;
          if (v[2]) begin
            tx_on[c] = 1; status[c] |= ST_TXRDY | ST_TXEMT; irq_stat |= tx_irq(c);
          end
          if (v[3]) begin
            tx_on[c] = 0; tx_stop(c);
          end
          case (v[6:4])
            3'd1: mode_ptr[c] = 0;
            3'd2: begin
              status[c] &= ~(ST_RXRDY | ST_RXFULL); irq_stat &= ~rx_irq(c);
            end
            3'd3: tx_stop(c);
            default: ;
          endcase
        end
        default: begin
          tx_hold[c] = v;
          tx_stop(c);
          tx_wait[c] = (tx_delay != 0) ? tx_delay : 16'd1;
          if (mode_two[c][7] && rx_on[c]) ok = take_byte(c, v);
        end
      endcase
    end else begin
      case (off)
        REG_ACR:   aux = v;
        REG_IMR:   irq_msk = v;
        REG_CTUR:  cnt_reload = {v, cnt_reload[7:0]};
        REG_CTLR:  cnt_reload = {cnt_reload[15:8], v};
        REG_IVR:   irq_vec = v;
        REG_OPCR:  op_cfg = v;
        REG_OPSET: drive_pins(op_reg | v);
        default:   drive_pins(op_reg & ~v);
      endcase
    end
  endfunction

  function automatic logic [7:0] read_reg(logic [3:0] off);
    logic c;
    logic [7:0] v;
    c = off[3];
    if (!off[2]) begin
      case (off[2:0])
        REG_MODE: begin
          v = mode_ptr[c] ? mode_two[c] : mode_one[c];
          mode_ptr[c] = 1;
          return v;
        end
        REG_CSR: return status[c];
        REG_CMD: return 8'h00;
        default: begin
          status[c] &= ~(ST_RXRDY | ST_RXFULL);
          irq_stat &= ~rx_irq(c);
          return rx_hold[c];
        end
      endcase
    end
    case (off)
      REG_ACR, REG_OPCR: return 8'hFF;
      REG_IMR:  return irq_stat;
      REG_CTUR: return cnt_now[15:8];
      REG_CTLR: return cnt_now[7:0];
      REG_IVR:  return irq_vec;
      REG_OPSET: begin
        cnt_run = 1; cnt_now = cnt_reload; irq_stat &= ~IRQ_CNT;
        return cnt_now[15:8];
      end
      default: begin
        cnt_run = 0; irq_stat &= ~IRQ_CNT;
        return cnt_now[7:0];
      end
    endcase
  endfunction

  function automatic logic advance(logic [31:0] cyc);
    logic sent;
    sent = 0;
    for (int c = 0; c < 2; c++) begin
      if (tx_wait[c] != 0) begin
        if (cyc >= {16'd0, tx_wait[c]}) begin
          tx_wait[c] = 0;
          status[c] |= ST_TXRDY | ST_TXEMT;
          irq_stat |= tx_irq(c[0]);
          queue_event(c[0]);
          sent = 1;
        end else tx_wait[c] = tx_wait[c] - cyc[15:0];
      end
    end
    if (cnt_run && cnt_reload != 0) begin
      if (cyc >= {16'd0, cnt_now}) begin
        cnt_now = cnt_reload; irq_stat |= IRQ_CNT;
      end else cnt_now = cnt_now - cyc[15:0];
    end
    return sent;
  endfunction

  function automatic uart_result_t predict_word(logic [47:0] w);
    uart_result_t r;
    evt_t e;
    r = '0;
    case (op_e'(w[2:0]))
      OP_WRITE: write_reg(w[6:3], w[14:7]);
      OP_READ:  r.read_data = read_reg(w[6:3]);
      OP_TICK:  r.done = advance(w[46:15]);
      OP_RX_A:  r.done = take_byte(1'b0, w[14:7]) & 1'b0;
      OP_RX_B:  r.done = take_byte(1'b1, w[14:7]);
      OP_POP: begin
        if (evt_rd != evt_wr) begin
          e = evt_mem[evt_rd[3:0]];
          r.done = 1; r.channel = e.chan; r.byte_v = e.byte_v; r.clock_select = e.clk;
          r.mode_one = e.m1; r.mode_two = e.m2; r.command = e.cmd;
          evt_rd = evt_rd + 5'd1;
        end
      end
      OP_CHG: begin
        r.read_data = op_changed; op_changed = 0;
      end
      default: ;
    endcase
    r.port_level = op_pins;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    uart_result_t act, exp_r;
    if (!rst_ni) begin
      clear_state();
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) tx_delay = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        act = m_axis_tdata[57:0];
        results_o++;
        if (expected_q.size() == 0) begin
          $error("result word with no expectation: %h", m_axis_tdata);
          fails_o++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("read_data", exp_r.read_data, act.read_data);
          check_field("done_flag", exp_r.done, act.done);
          check_field("event_channel", exp_r.channel, act.channel);
          check_field("event_byte", exp_r.byte_v, act.byte_v);
          check_field("event_clock_select", exp_r.clock_select, act.clock_select);
          check_field("event_mode_one", exp_r.mode_one, act.mode_one);
          check_field("event_mode_two", exp_r.mode_two, act.mode_two);
          check_field("event_command", exp_r.command, act.command);
          check_field("port_level", exp_r.port_level, act.port_level);
        end
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(predict_word(s_axis_tdata));
      pending_o = expected_q.size();
    end
  end

  initial begin
    fails_o = 0;
    results_o = 0;
    pending_o = 0;
  end
endmodule

// File: dv/testbench.sv
// Testbench top: stimulus, backpressure and verdict for the dual UART block.
`timescale 1ns / 1ps
module testbench;
  import duart_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [15:0] cfg_wdata_i = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  int          pending, fails, results;
  int          burst_left = 0;
  int          sent_words = 0;
  int          settle;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  dual_uart_register_model u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  duart_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .pending_o(pending), .fails_o(fails), .results_o(results)
  );

  // receiver stall pattern: free-running, random, sparse, long stalls
  initial begin
    int mode;
    int hold;
    mode = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: m_axis_tready = 1;
        1: m_axis_tready = 1'($urandom_range(0, 1));
        2: m_axis_tready = ($urandom_range(0, 3) == 0);
        default: begin
          if (hold > 0) begin
            hold--; m_axis_tready = 0;
          end else begin
            m_axis_tready = 1;
            if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, 20);
          end
        end
      endcase
    end
  end

  task automatic send_word(op_e op, logic [3:0] off, logic [7:0] d, logic [31:0] cyc);
    s_axis_tdata = {1'b0, cyc, d, off, op};
    s_axis_tvalid = 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_words++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else burst_left--;
  endtask

  // sender holds off until every expected word is back, then writes the delay
  task automatic set_delay(logic [15:0] v);
    s_axis_tvalid = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i = 1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  task automatic setup_channel(logic [3:0] base, logic loop);
    send_word(OP_WRITE, base | {1'b0, REG_CMD}, 8'h10, 0);
    send_word(OP_WRITE, base | {1'b0, REG_MODE}, 8'($urandom), 0);
    send_word(OP_WRITE, base | {1'b0, REG_MODE}, {loop, 7'($urandom)}, 0);
    send_word(OP_WRITE, base | {1'b0, REG_CSR}, 8'($urandom), 0);
    send_word(OP_WRITE, base | {1'b0, REG_CMD}, 8'h05, 0);
  endtask

  task automatic random_word();
    int r;
    logic [3:0] base;
    logic [31:0] cyc;
    r = $urandom_range(0, 99);
    base = $urandom_range(0, 1) ? 4'h8 : 4'h0;
    cyc = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
    if (r < 4) setup_channel(base, 1'($urandom_range(0, 1)));
    else if (r < 18) send_word(OP_WRITE, base | {1'b0, REG_DATA}, 8'($urandom), 0);
    else if (r < 32) send_word(OP_TICK, 4'($urandom), 8'($urandom), cyc);
    else if (r < 44) send_word(OP_POP, 4'($urandom), 8'($urandom), $urandom);
    else if (r < 52) send_word(OP_RX_A, 4'($urandom), 8'($urandom), $urandom);
    else if (r < 60) send_word(OP_RX_B, 4'($urandom), 8'($urandom), $urandom);
    else if (r < 74) send_word(OP_READ, 4'($urandom), 8'($urandom), $urandom);
    else if (r < 88) send_word(OP_WRITE, 4'($urandom), 8'($urandom), $urandom);
    else if (r < 95) send_word(OP_CHG, 4'($urandom), 8'($urandom), $urandom);
    else if (r < 98) send_word(OP_WRITE, base | {1'b0, REG_CMD}, 8'($urandom), 0);
    else send_word(OP_NONE, 4'($urandom), 8'($urandom), $urandom);
  endtask

  initial begin
    logic [15:0] delays[5];
    delays = '{16'd1, 16'd0, 16'd65535, 16'd37, 16'd100};
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: reads after reset, loopback on both channels, refusal on B,
    // counter with and without reload, empty pop, unused opcode
    send_word(OP_POP, 4'h0, 8'h00, 0);
    send_word(OP_READ, REG_IVR, 8'h00, 0);
    send_word(OP_RX_A, 4'h0, 8'hFF, 0);
    setup_channel(4'h0, 1'b1);
    setup_channel(4'h8, 1'b1);
    send_word(OP_WRITE, 4'hB, 8'hA5, 0);
    send_word(OP_RX_B, 4'h0, 8'h5A, 0);
    send_word(OP_WRITE, 4'h3, 8'h00, 0);
    send_word(OP_TICK, 4'h0, 8'h00, 32'hFFFF_FFFF);
    send_word(OP_READ, 4'hE, 8'h00, 0);
    send_word(OP_WRITE, REG_CTLR, 8'h10, 0);
    send_word(OP_READ, 4'hE, 8'h00, 0);
    send_word(OP_TICK, 4'h0, 8'h00, 32'd20);
    send_word(OP_READ, REG_IMR, 8'h00, 0);
    send_word(OP_WRITE, REG_OPSET, 8'hFF, 0);
    send_word(OP_CHG, 4'h0, 8'h00, 0);
    send_word(OP_WRITE, REG_OPCLR, 8'h0F, 0);
    send_word(OP_NONE, 4'hF, 8'hFF, 32'hFFFF_FFFF);
    send_word(OP_POP, 4'h0, 8'h00, 0);

    foreach (delays[i]) begin
      set_delay(delays[i]);
      repeat (90) random_word();
      if (i == 0) begin
        // overflow the event queue with short delays
        repeat (20) begin
          send_word(OP_WRITE, 4'h3, 8'($urandom), 0);
          send_word(OP_TICK, 4'h0, 8'h00, 32'd5);
        end
        repeat (18) send_word(OP_POP, 4'h0, 8'h00, 0);
      end
    end

    s_axis_tvalid = 0;
    settle = 0;
    while (pending != 0 && settle < 100000) begin
      @(negedge clk_i);
      settle++;
    end
    repeat (5) @(negedge clk_i);
    $display("Run covered %0d input words and %0d result words over five tx delays,",
             sent_words, results);
    $display("with loopback, queue overflow, counter and output port traffic.");
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule

// File: filelist.f
sv/duart_pkg.sv
sv/duart_evq.sv
sv/dual_uart_register_model.sv
dv/duart_checker.sv
dv/testbench.sv
